>>> src/fotq_pkg.sv
// shared types and codes for the frame-ordered transaction queue
`timescale 1ns / 1ps
package fotq_pkg;

  localparam int unsigned OCC_W = 5;

  typedef enum logic [1:0] {
    MODE_ENQUEUE   = 2'd0,
    MODE_DEQUEUE   = 2'd1,
    MODE_FLUSH_ALL = 2'd2,
    MODE_FLUSH_DEV = 2'd3
  } fotq_mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOT_DUE = 2'd2,
    ST_FULL    = 2'd3
  } fotq_status_e;

  typedef struct packed {
    fotq_status_e status;
    logic         granted;
  } fotq_res_t;

endpackage

>>> src/fotq_entry_ram.sv
// entry memory: one write port, one read port with registered read data
`timescale 1ns / 1ps
module fotq_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned WIDTH = 37
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    wa_i,
  input  logic [WIDTH-1:0] wd_i,
  input  logic             re_i,
  input  logic [AW-1:0]    ra_i,
  output logic [WIDTH-1:0] rd_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

>>> src/fotq_seq.sv
// operation sequencer: streams reads through the entry memory and writes back
`timescale 1ns / 1ps
module fotq_seq #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned FRAME_BITS  = 14,
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned DEVICE_BITS = 7,
  parameter int unsigned AW          = 4,
  parameter int unsigned CW          = 5,
  parameter int unsigned EW          = 37
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fotq_pkg::fotq_mode_e   mode_i,
  input  logic [HANDLE_BITS-1:0] handle_i,
  input  logic [FRAME_BITS-1:0]  frame_i,
  input  logic [DEVICE_BITS-1:0] device_i,
  input  logic                   out_free_i,
  output logic                   done_o,
  output fotq_pkg::fotq_res_t    res_o,
  output logic [HANDLE_BITS-1:0] handle_o,
  output logic [CW-1:0]          cnt_o,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_wa_o,
  output logic [EW-1:0]          mem_wd_o,
  output logic                   mem_re_o,
  output logic [AW-1:0]          mem_ra_o,
  input  logic [EW-1:0]          mem_rd_i
);
  import fotq_pkg::*;

  localparam logic [FRAME_BITS-1:0] FrameHalf = {1'b0, {(FRAME_BITS-1){1'b1}}};

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_SHIFT_UP = 7'b0000100,
    S_DEQ_HEAD = 7'b0001000,
    S_SHIFT_DN = 7'b0010000,
    S_PURGE    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  function automatic logic frame_later(input logic [FRAME_BITS-1:0] a,
                                       input logic [FRAME_BITS-1:0] b);
    logic [FRAME_BITS-1:0] diff;
    diff = a - b;
    return (a != b) && (diff < FrameHalf);
  endfunction

  state_e                 state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          ptr_q, ptr_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          w_q, w_d;
  logic                   pend_q;
  logic [AW-1:0]          pidx_q;
  logic [HANDLE_BITS-1:0] h_q, h_d;
  logic [FRAME_BITS-1:0]  f_q, f_d;
  logic [DEVICE_BITS-1:0] d_q, d_d;
  fotq_res_t              res_q, res_d;
  logic [HANDLE_BITS-1:0] gh_q, gh_d;

  logic [HANDLE_BITS-1:0] rd_handle;
  logic [FRAME_BITS-1:0]  rd_frame;
  logic [DEVICE_BITS-1:0] rd_device;
  logic [CW-1:0]          ptr_m1;

  assign rd_handle = mem_rd_i[EW-1 -: HANDLE_BITS];
  assign rd_frame  = mem_rd_i[DEVICE_BITS +: FRAME_BITS];
  assign rd_device = mem_rd_i[0 +: DEVICE_BITS];
  assign ptr_m1    = ptr_q - CW'(1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    pos_d    = pos_q;
    w_d      = w_q;
    h_d      = h_q;
    f_d      = f_q;
    d_d      = d_q;
    res_d    = res_q;
    gh_d     = gh_q;
    mem_re_o = 1'b0;
    mem_ra_o = ptr_q[AW-1:0];
    mem_we_o = 1'b0;
    mem_wa_o = pidx_q;
    mem_wd_o = mem_rd_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          h_d           = handle_i;
          f_d           = frame_i;
          d_d           = device_i;
          res_d.status  = ST_OK;
          res_d.granted = 1'b0;
          gh_d          = '0;
          ptr_d         = '0;
          w_d           = '0;
          case (mode_i)
            MODE_ENQUEUE: begin
              if (cnt_q == CW'(DEPTH)) begin
                res_d.status = ST_FULL;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            MODE_DEQUEUE: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                mem_re_o = 1'b1;
                mem_ra_o = '0;
                ptr_d    = CW'(1);
                state_d  = S_DEQ_HEAD;
              end
            end
            MODE_FLUSH_ALL: begin
              cnt_d   = '0;
              state_d = S_DONE;
            end
            MODE_FLUSH_DEV: begin
              state_d = S_PURGE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // first entry later than the new frame marks the insertion point
        if (pend_q && frame_later(rd_frame, f_q)) begin
          pos_d   = CW'(pidx_q);
          ptr_d   = cnt_q;
          state_d = S_SHIFT_UP;
        end else if (ptr_q < cnt_q) begin
          mem_re_o = 1'b1;
          mem_ra_o = ptr_q[AW-1:0];
          ptr_d    = ptr_q + CW'(1);
        end else if (!pend_q) begin
          pos_d   = cnt_q;
          ptr_d   = cnt_q;
          state_d = S_SHIFT_UP;
        end
      end
      S_SHIFT_UP: begin
        if (pend_q) begin
          mem_we_o = 1'b1;
          mem_wa_o = pidx_q + AW'(1);
          mem_wd_o = mem_rd_i;
        end
        if (ptr_q > pos_q) begin
          mem_re_o = 1'b1;
          mem_ra_o = ptr_m1[AW-1:0];
          ptr_d    = ptr_m1;
        end else if (!pend_q) begin
          mem_we_o = 1'b1;
          mem_wa_o = pos_q[AW-1:0];
          mem_wd_o = {h_q, f_q, d_q};
          cnt_d    = cnt_q + CW'(1);
          state_d  = S_DONE;
        end
      end
      S_DEQ_HEAD: begin
        if (frame_later(rd_frame, f_q)) begin
          res_d.status = ST_NOT_DUE;
          state_d      = S_DONE;
        end else begin
          res_d.granted = 1'b1;
          gh_d          = rd_handle;
          state_d       = S_SHIFT_DN;
        end
      end
      S_SHIFT_DN: begin
        if (pend_q) begin
          mem_we_o = 1'b1;
          mem_wa_o = pidx_q - AW'(1);
          mem_wd_o = mem_rd_i;
        end
        if (ptr_q < cnt_q) begin
          mem_re_o = 1'b1;
          mem_ra_o = ptr_q[AW-1:0];
          ptr_d    = ptr_q + CW'(1);
        end else if (!pend_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_PURGE: begin
        // compaction: survivors move down to the write pointer
        if (pend_q && (rd_device != d_q)) begin
          mem_we_o = 1'b1;
          mem_wa_o = w_q[AW-1:0];
          mem_wd_o = mem_rd_i;
          w_d      = w_q + CW'(1);
        end
        if (ptr_q < cnt_q) begin
          mem_re_o = 1'b1;
          mem_ra_o = ptr_q[AW-1:0];
          ptr_d    = ptr_q + CW'(1);
        end else if (!pend_q) begin
          cnt_d   = w_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      pos_q   <= '0;
      w_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      pos_q   <= pos_d;
      w_q     <= w_d;
      pend_q  <= mem_re_o;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= mem_ra_o;
    h_q    <= h_d;
    f_q    <= f_d;
    d_q    <= d_d;
    res_q  <= res_d;
    gh_q   <= gh_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign done_o     = (state_q == S_DONE) && out_free_i;
  assign res_o      = res_q;
  assign handle_o   = gh_q;
  assign cnt_o      = cnt_q;

endmodule

>>> src/frame_ordered_transaction_queue_top.sv
// top level of the frame-ordered transaction queue
`timescale 1ns / 1ps
// operation steps: enqueue does a forward scan to the slot, then a backward shift of
//   the entries behind it; dequeue reads the head and shifts the rest down; flush device
//   compacts the surviving entries; flush all clears the entry count directly
// throughput: one word at a time; the entry memory moves one entry a cycle
// a finished result sits in the output register while the next word is accepted
// reset: asynchronous, active low; the queue comes up empty, memory is not cleared
module frame_ordered_transaction_queue_top #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned FRAME_BITS  = 14,
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned DEVICE_BITS = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             mode_i,
  input  logic [HANDLE_BITS-1:0] transfer_handle_i,
  input  logic [FRAME_BITS-1:0]  frame_number_i,
  input  logic [DEVICE_BITS-1:0] device_id_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic                   granted_o,
  output logic [HANDLE_BITS-1:0] granted_handle_o,
  output logic [fotq_pkg::OCC_W-1:0] occupancy_o
);
  import fotq_pkg::*;

  // memory address, entry count and packed entry widths
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = HANDLE_BITS + FRAME_BITS + DEVICE_BITS;

  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [EW-1:0]          mem_wd;
  logic                   mem_re;
  logic [AW-1:0]          mem_ra;
  logic [EW-1:0]          mem_rd;

  logic                   seq_done;
  fotq_res_t              seq_res;
  logic [HANDLE_BITS-1:0] seq_handle;
  logic [CW-1:0]          seq_cnt;
  logic                   out_free;

  // output register state
  logic                   out_valid_q, out_valid_d;
  fotq_res_t              out_res_q;
  logic [HANDLE_BITS-1:0] out_handle_q;
  logic [OCC_W-1:0]       out_occ_q;

  // entries held as {handle, frame, device}, head at address zero
  fotq_entry_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .WIDTH (EW)
  ) u_ram (
    .clk_i (clk_i),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .re_i  (mem_re),
    .ra_i  (mem_ra),
    .rd_o  (mem_rd)
  );

  fotq_seq #(
    .DEPTH       (DEPTH),
    .FRAME_BITS  (FRAME_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .DEVICE_BITS (DEVICE_BITS),
    .AW          (AW),
    .CW          (CW),
    .EW          (EW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (fotq_mode_e'(mode_i)),
    .handle_i   (transfer_handle_i),
    .frame_i    (frame_number_i),
    .device_i   (device_id_i),
    .out_free_i (out_free),
    .done_o     (seq_done),
    .res_o      (seq_res),
    .handle_o   (seq_handle),
    .cnt_o      (seq_cnt),
    .mem_we_o   (mem_we),
    .mem_wa_o   (mem_wa),
    .mem_wd_o   (mem_wd),
    .mem_re_o   (mem_re),
    .mem_ra_o   (mem_ra),
    .mem_rd_i   (mem_rd)
  );

  // the slot is free when empty or being drained this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = seq_done || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      out_res_q    <= seq_res;
      out_handle_q <= seq_handle;
      out_occ_q    <= OCC_W'(seq_cnt);  // reported modulo 32
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign granted_o        = out_res_q.granted;
  assign granted_handle_o = out_handle_q;
  assign occupancy_o      = out_occ_q;

  // entry count never goes past the memory depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) seq_cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  // streamed read and write-back never touch the same entry in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("read and write of the same entry overlap");

  // a grant comes only with status ok, and no grant leaves the handle at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (granted_o ? (status_o == ST_OK) : (granted_handle_o == '0)))
    else $error("grant and status disagree");

endmodule
